// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the depth-first walk block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset.
`define GDFW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define GDFW_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define GDFW_ASSERT(lbl, clk, rst_n, prop, msg)
`define GDFW_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- design/gdfw_pkg.sv -----
// ----------------------------------------------------------------------------
// gdfw_pkg
// Sizes, codes and state type of the depth-first walk block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdfw_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 16;
    localparam int START_VERTEX = 1;
    localparam int VCOUNT_RST   = 9;

    // Field width of a vertex number on the ports.
    localparam int VTX_W  = 5;
    localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DIDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DCNT_W = $clog2(MAX_DEGREE + 1);
    localparam int SDEP_W = $clog2(MAX_VERTICES + 1);
    localparam int NBR_AW = VIDX_W + DIDX_W;

    typedef logic [VTX_W-1:0] t_vtx;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_WALK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_EDGE_C,
        ST_POP,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ----- design/gdfw_if.sv -----
// ----------------------------------------------------------------------------
// gdfw interfaces
// Valid/ready channels for requests, visit words and the configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gdfw_req_if;
    import gdfw_pkg::*;
    logic valid;
    logic ready;
    logic req_type;
    t_vtx edge_from;
    t_vtx edge_to;
    modport source (output valid, req_type, edge_from, edge_to, input ready);
    modport sink   (input valid, req_type, edge_from, edge_to, output ready);
endinterface

interface gdfw_visit_if;
    import gdfw_pkg::*;
    logic valid;
    logic ready;
    t_vtx visit_vertex;
    logic last_visit;
    modport source (output valid, visit_vertex, last_visit, input ready);
    modport sink   (input valid, visit_vertex, last_visit, output ready);
endinterface

interface gdfw_cfg_if;
    import gdfw_pkg::*;
    logic valid;
    logic ready;
    t_vtx vertex_count;
    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

// ----- design/gdfw_nbr_ram.sv -----
// ----------------------------------------------------------------------------
// gdfw_nbr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdfw_nbr_ram #(
    parameter int AW = 8,
    parameter int DW = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/graph_depth_first_walk.sv -----
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// Undirected graph loader and depth-first walker with valid/ready channels.
// ----------------------------------------------------------------------------
// An add-edge word (req_type 0) appends each endpoint to the other's neighbor
// list; edges with an endpoint of zero or above the vertex count, or that do
// not fit the degree limit, are dropped silently. An add-edge word steps
// through accept, degree read, first append and second append. A start word
// (req_type 1) walks the graph from vertex 1 and returns one visit word per
// reachable vertex, the final one flagged by last_visit. Each visited vertex
// takes a pop, one neighbor RAM read per list entry (the single read port of
// the neighbor RAM sets this), and an emit step that waits for the output
// register to free up. No clearing pass is needed after reset: degree counts
// and visited marks reset in flops, and only neighbor entries below a list's
// degree are ever read. Write vertex_count only while the block is idle; it
// is saturated to the range 1..MAX_VERTICES internally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module graph_depth_first_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gdfw_cfg_if.sink            i_cfg,
    gdfw_req_if.sink            i_req,
    gdfw_visit_if.source        o_visit
);

    import gdfw_pkg::*;

    localparam logic [MAX_VERTICES-1:0] START_MARK =
        MAX_VERTICES'(1) << (START_VERTEX - 1);

    // Control state
    t_state              r_state, n_state;
    t_vtx                r_vcount;
    logic [SDEP_W-1:0]   r_depth, n_depth;
    logic [DCNT_W-1:0]   r_k, n_k;
    logic                r_rd_vld, n_rd_vld;
    logic                r_out_vld, n_out_vld;
    logic [DCNT_W-1:0]   r_deg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_mark;

    // Payload
    t_vtx                r_a, n_a;
    t_vtx                r_b, n_b;
    logic [DCNT_W-1:0]   r_deg_a, n_deg_a;
    t_vtx                r_cur, n_cur;
    logic [DCNT_W-1:0]   r_cur_deg, n_cur_deg;
    t_vtx                r_stack [MAX_VERTICES];
    t_vtx                r_out_vtx, n_out_vtx;
    logic                r_out_last, n_out_last;

    // Combinational controls
    t_vtx                used_cnt;
    logic                req_acc;
    logic                a_ok, b_ok;
    logic [VIDX_W-1:0]   deg_ridx;
    logic [DCNT_W-1:0]   deg_rdata;
    logic                deg_we;
    logic [VIDX_W-1:0]   deg_widx;
    logic [DCNT_W-1:0]   deg_wdata;
    logic                mark_clr;
    logic                mark_set;
    logic [VIDX_W-1:0]   mark_idx;
    logic                stk_we;
    logic [VIDX_W-1:0]   stk_widx;
    t_vtx                stk_wdata;
    t_vtx                stk_top;
    logic                nbr_we;
    logic [NBR_AW-1:0]   nbr_waddr;
    t_vtx                nbr_wdata;
    logic [NBR_AW-1:0]   nbr_raddr;
    t_vtx                nbr_rdata;
    logic                room_ok;
    logic                issue;
    logic                push_ok;
    logic                out_load;

    // Saturate the vertex count to 1..MAX_VERTICES.
    always_comb begin
        priority if (r_vcount == '0) begin
            used_cnt = VTX_W'(1);
        end else if (r_vcount > VTX_W'(MAX_VERTICES)) begin
            used_cnt = VTX_W'(MAX_VERTICES);
        end else begin
            used_cnt = r_vcount;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    assign a_ok = (i_req.edge_from != '0) && (i_req.edge_from <= used_cnt);
    assign b_ok = (i_req.edge_to != '0) && (i_req.edge_to <= used_cnt);

    assign stk_top   = r_stack[VIDX_W'(r_depth - SDEP_W'(1))];

    // One degree read port, address chosen by the step in progress.
    always_comb begin
        unique case (r_state)
            ST_EDGE_A:            deg_ridx = VIDX_W'(r_a - VTX_W'(1));
            ST_EDGE_B, ST_EDGE_C: deg_ridx = VIDX_W'(r_b - VTX_W'(1));
            default:              deg_ridx = VIDX_W'(stk_top - VTX_W'(1));
        endcase
    end
    assign deg_rdata = r_deg[deg_ridx];

    // Drop the edge whole if either list lacks room; a self-loop takes two.
    always_comb begin
        if (r_a == r_b) begin
            room_ok = ({1'b0, r_deg_a} + (DCNT_W+1)'(2)) <= (DCNT_W+1)'(MAX_DEGREE);
        end else begin
            room_ok = (r_deg_a < DCNT_W'(MAX_DEGREE)) && (deg_rdata < DCNT_W'(MAX_DEGREE));
        end
    end

    // Neighbor scan: issue one read a cycle, test the word that returns.
    assign issue     = (r_k < r_cur_deg);
    assign nbr_raddr = {VIDX_W'(r_cur - VTX_W'(1)), DIDX_W'(r_k)};
    assign push_ok   = r_rd_vld && (nbr_rdata != '0) && (nbr_rdata <= used_cnt)
                       && !r_mark[VIDX_W'(nbr_rdata - VTX_W'(1))]
                       && (r_depth < SDEP_W'(MAX_VERTICES));

    assign out_load = (r_state == ST_EMIT) && (!r_out_vld || o_visit.ready);

    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_k        = r_k;
        n_rd_vld   = 1'b0;
        n_a        = r_a;
        n_b        = r_b;
        n_deg_a    = r_deg_a;
        n_cur      = r_cur;
        n_cur_deg  = r_cur_deg;
        n_out_vtx  = r_out_vtx;
        n_out_last = r_out_last;
        deg_we     = 1'b0;
        deg_widx   = VIDX_W'(r_a - VTX_W'(1));
        deg_wdata  = r_deg_a + DCNT_W'(1);
        mark_clr   = 1'b0;
        mark_set   = 1'b0;
        mark_idx   = VIDX_W'(nbr_rdata - VTX_W'(1));
        stk_we     = 1'b0;
        stk_widx   = VIDX_W'(r_depth);
        stk_wdata  = nbr_rdata;
        nbr_we     = 1'b0;
        nbr_waddr  = {VIDX_W'(r_a - VTX_W'(1)), DIDX_W'(r_deg_a)};
        nbr_wdata  = r_b;

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (o_visit.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_a = i_req.edge_from;
                    n_b = i_req.edge_to;
                    if (i_req.req_type == REQ_WALK) begin
                        // Reset marks, seed the stack with the start vertex.
                        mark_clr  = 1'b1;
                        stk_we    = 1'b1;
                        stk_widx  = '0;
                        stk_wdata = VTX_W'(START_VERTEX);
                        n_depth   = SDEP_W'(1);
                        n_state   = ST_POP;
                    end else if (a_ok && b_ok) begin
                        n_state = ST_EDGE_A;
                    end
                end
            end
            ST_EDGE_A: begin
                n_deg_a = deg_rdata;
                n_state = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                if (room_ok) begin
                    nbr_we  = 1'b1;
                    deg_we  = 1'b1;
                    n_state = ST_EDGE_C;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EDGE_C: begin
                // Degree of b is already updated here when the edge is a self-loop.
                nbr_we    = 1'b1;
                nbr_waddr = {VIDX_W'(r_b - VTX_W'(1)), DIDX_W'(deg_rdata)};
                nbr_wdata = r_a;
                deg_we    = 1'b1;
                deg_widx  = VIDX_W'(r_b - VTX_W'(1));
                deg_wdata = deg_rdata + DCNT_W'(1);
                n_state   = ST_IDLE;
            end
            ST_POP: begin
                n_cur     = stk_top;
                n_cur_deg = deg_rdata;
                n_depth   = r_depth - SDEP_W'(1);
                n_k       = '0;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                if (issue) begin
                    n_k      = r_k + DCNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (push_ok) begin
                    stk_we   = 1'b1;
                    mark_set = 1'b1;
                    n_depth  = r_depth + SDEP_W'(1);
                end
                // The last returning word is tested in this same cycle.
                if (!issue) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register frees up.
                if (out_load) begin
                    n_out_vtx  = r_cur;
                    n_out_last = (r_depth == '0);
                    n_state    = (r_depth == '0) ? ST_IDLE : ST_POP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vcount  <= VTX_W'(VCOUNT_RST);
            r_depth   <= '0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mark    <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_deg[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_k       <= n_k;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_vcount <= i_cfg.vertex_count;
            end
            if (deg_we) begin
                r_deg[deg_widx] <= deg_wdata;
            end
            if (mark_clr) begin
                r_mark <= START_MARK;
            end else if (mark_set) begin
                r_mark[mark_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_deg_a    <= n_deg_a;
        r_cur      <= n_cur;
        r_cur_deg  <= n_cur_deg;
        r_out_vtx  <= n_out_vtx;
        r_out_last <= n_out_last;
        if (stk_we) begin
            r_stack[stk_widx] <= stk_wdata;
        end
    end

    gdfw_nbr_ram #(
        .AW (NBR_AW),
        .DW (VTX_W)
    ) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    assign o_visit.valid        = r_out_vld;
    assign o_visit.visit_vertex = r_out_vtx;
    assign o_visit.last_visit   = r_out_last;

    `GDFW_NEVER(a_stack_bound, i_clk, i_rst_n, r_depth > SDEP_W'(MAX_VERTICES), "stack depth over limit")
    `GDFW_NEVER(a_no_wr_in_walk, i_clk, i_rst_n, nbr_we && (r_state == ST_POP || r_state == ST_SCAN || r_state == ST_EMIT), "neighbor RAM written during walk")
    `GDFW_ASSERT(a_mid_walk_busy, i_clk, i_rst_n, (o_visit.valid && !o_visit.last_visit) |-> (r_state != ST_IDLE), "walk ended without a last word")
    `GDFW_ASSERT(a_deg_bound, i_clk, i_rst_n, deg_we |-> (deg_wdata <= DCNT_W'(MAX_DEGREE)), "degree over limit")
    `GDFW_ASSERT(a_start_marked, i_clk, i_rst_n, (r_state == ST_SCAN) |-> r_mark[START_VERTEX-1], "start vertex not marked in walk")

endmodule
